### rtl/mf3_pkg.sv
// Package for the 3x3 median filter: sizes, codes and the word types of both channels.
// Used by every module under rtl; it depends on nothing else.
`default_nettype none

package mf3_pkg;

	localparam int MAX_LINE = 1024;
	localparam int ROWS_LIMIT = 1024;
	localparam int CFG_W = 11;
	localparam int COL_W = $clog2(MAX_LINE);
	localparam int ROW_W = $clog2(ROWS_LIMIT + 1);
	localparam int CNT_W = $clog2(MAX_LINE * ROWS_LIMIT + 2 * MAX_LINE + 2);
	localparam int PROD_W = 2 * CFG_W;
	localparam int LINE_RESET = (MAX_LINE < 1024) ? MAX_LINE : 1024;
	localparam int ROWS_RESET = ROWS_LIMIT;

	typedef logic [7:0] pix_t;
	typedef pix_t [2:0] wcol_t;
	typedef pix_t [8:0] cells_t;

	typedef enum logic {
		CMD_PIXEL = 1'b0,
		CMD_DRAIN = 1'b1
	} cmd_t;

	typedef enum logic {
		REG_LINE_LENGTH = 1'b0,
		REG_FRAME_ROWS  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		cmd_t command;
		pix_t pixel;
	} pix_word_t;

	typedef struct packed {
		pix_t filtered;
		logic frame_end;
	} res_word_t;

	typedef struct packed {
		pix_t upper;
		pix_t middle;
	} lpair_t;

	typedef struct packed {
		cells_t cells;
		logic   frame_end;
	} med_in_t;

endpackage

`default_nettype wire

### rtl/median_filter_3x3.sv
// 3x3 median filter over an 8-bit grayscale raster stream, zero padded at the frame border.
// Every accepted word but a drain word inside a frame shifts the window by one column, so one
// word per clock is taken as long as the result side keeps up; the line store (one read and
// one write per word) and the column shift of the window set that rate. The result for a
// pixel leaves line_length+1 words after it, passing the stage-1 register and the median
// pipeline behind the word that completes it; after the last pixel of a frame,
// line_length+1 drain words flush the pending results and the last one carries frame_end. A
// drain word inside a frame is taken and dropped. Writing line_length or frame_rows restarts
// the frame. Depends on mf3_pkg, mf3_line_store, mf3_column_cell and mf3_median.
`default_nettype none

module median_filter_3x3 (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       pix_valid,
	output logic                            pix_stall,
	input  wire mf3_pkg::pix_word_t         pix_word,
	output logic                            res_valid,
	input  wire logic                       res_stall,
	output mf3_pkg::res_word_t              res_word,
	input  wire logic                       cfg_wr_en,
	input  wire mf3_pkg::cfg_reg_t          cfg_index,
	input  wire logic [mf3_pkg::CFG_W-1:0]  cfg_data
);

	localparam int COL_W = mf3_pkg::COL_W;
	localparam int ROW_W = mf3_pkg::ROW_W;
	localparam int CFG_W = mf3_pkg::CFG_W;
	localparam int CNT_W = mf3_pkg::CNT_W;
	localparam int PROD_W = mf3_pkg::PROD_W;

	function automatic logic [CFG_W-1:0] sat_cfg(logic [CFG_W-1:0] v, int unsigned lim);
		logic [CFG_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = CFG_W'(1);
		end else if (32'(v) > 32'(lim)) begin
			r = CFG_W'(lim);
		end
		return r;
	endfunction

	// Configuration and frame counters.
	logic [CFG_W-1:0]  len_q, rows_q, new_len, new_rows;
	logic [PROD_W-1:0] prod;
	logic [CNT_W-1:0]  total_q, shift_cnt_q, thr_res, thr_last;
	logic [COL_W-1:0]  col_q, col_nxt, ccol, len_m1;
	logic [ROW_W-1:0]  row_q;

	// Step decode.
	logic              in_frame, shifts, pix_acc, step;
	logic              has_res, is_last, col_wrap, row_end;
	logic              at_top, at_bottom, at_left, at_right;
	logic [8:0]        mask;
	mf3_pkg::pix_t     x0;

	// Stage 1: line store read data and the word's window controls.
	logic              valid_s1, res_s1, last_s1, fwd_s1;
	mf3_pkg::pix_t     x_s1, fa_s1, fb_s1;
	logic [COL_W-1:0]  col_s1;
	logic [8:0]        mask_s1;
	mf3_pkg::lpair_t   rd_q, wr_data;
	mf3_pkg::pix_t     a_eff, b_eff;
	logic              adv_s1, s1_go, med_ready, win_clear;

	mf3_pkg::wcol_t    win_q [3];
	mf3_pkg::wcol_t    win_din [3];
	mf3_pkg::med_in_t  med_in;

	always_comb begin
		new_len = len_q;
		new_rows = rows_q;
		case (cfg_index)
			mf3_pkg::REG_LINE_LENGTH: begin
				new_len = sat_cfg(cfg_data, mf3_pkg::MAX_LINE);
			end
			mf3_pkg::REG_FRAME_ROWS: begin
				new_rows = sat_cfg(cfg_data, mf3_pkg::ROWS_LIMIT);
			end
			default: begin
				new_len = len_q;
			end
		endcase
		prod = PROD_W'(new_len) * PROD_W'(new_rows);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= CFG_W'(mf3_pkg::LINE_RESET);
			rows_q <= CFG_W'(mf3_pkg::ROWS_RESET);
			total_q <= CNT_W'(mf3_pkg::LINE_RESET * mf3_pkg::ROWS_RESET);
		end else if (cfg_wr_en) begin
			len_q <= new_len;
			rows_q <= new_rows;
			total_q <= CNT_W'(prod);
		end
	end

	always_comb begin
		in_frame = shift_cnt_q < total_q;
		shifts = !in_frame || (pix_word.command == mf3_pkg::CMD_PIXEL);
		x0 = in_frame ? pix_word.pixel : '0;
		len_m1 = COL_W'(len_q - CFG_W'(1));
		ccol = (col_q == '0) ? len_m1 : col_q - 1'b1;
		col_wrap = ({1'b0, col_q} + 1'b1) >= (COL_W + 1)'(len_q);
		col_nxt = col_wrap ? '0 : col_q + 1'b1;
		thr_res = CNT_W'(len_q) + CNT_W'(1);
		thr_last = total_q + CNT_W'(len_q);
		has_res = shift_cnt_q >= thr_res;
		is_last = shift_cnt_q >= thr_last;
		row_end = ccol == len_m1;
		at_top = row_q != '0;
		at_bottom = ((ROW_W + 1)'(row_q) + 1'b1) < (ROW_W + 1)'(rows_q);
		at_left = ccol != '0;
		at_right = ccol != len_m1;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				mask[r * 3 + c] = (r != 0 || at_top) && (r != 2 || at_bottom) &&
				                  (c != 0 || at_left) && (c != 2 || at_right);
			end
		end
	end

	assign adv_s1 = !valid_s1 || med_ready;
	assign pix_stall = !adv_s1;
	assign pix_acc = pix_valid && !pix_stall;
	assign step = pix_acc && shifts;
	assign s1_go = valid_s1 && med_ready;
	assign win_clear = cfg_wr_en || (s1_go && last_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			shift_cnt_q <= '0;
		end else if (cfg_wr_en) begin
			col_q <= '0;
			row_q <= '0;
			shift_cnt_q <= '0;
		end else if (step) begin
			if (is_last) begin
				col_q <= '0;
				row_q <= '0;
				shift_cnt_q <= '0;
			end else begin
				col_q <= col_nxt;
				shift_cnt_q <= shift_cnt_q + 1'b1;
				if (has_res && row_end) begin
					row_q <= row_q + 1'b1;
				end
			end
		end
	end

	// With a one-pixel line the next word reads the entry the word ahead is writing.
	assign a_eff = fwd_s1 ? fa_s1 : rd_q.upper;
	assign b_eff = fwd_s1 ? fb_s1 : rd_q.middle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			x_s1 <= x0;
			col_s1 <= col_q;
			mask_s1 <= mask;
			res_s1 <= has_res;
			last_s1 <= is_last;
			fwd_s1 <= valid_s1 && (col_s1 == col_q);
			fa_s1 <= b_eff;
			fb_s1 <= x_s1;
		end
	end

	assign wr_data.upper = b_eff;
	assign wr_data.middle = x_s1;

	mf3_line_store u_line_store (
		.clk     (clk),
		.wr_en   (s1_go),
		.wr_addr (col_s1),
		.wr_data (wr_data),
		.rd_en   (step),
		.rd_addr (col_q),
		.rd_q    (rd_q)
	);

	assign win_din[0] = win_q[1];
	assign win_din[1] = win_q[2];
	assign win_din[2] = {x_s1, b_eff, a_eff};

	for (genvar c = 0; c < 3; c++) begin : g_col
		mf3_column_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (s1_go),
			.clear  (win_clear),
			.din    (win_din[c]),
			.col_q  (win_q[c])
		);
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				med_in.cells[r * 3 + c] = mask_s1[r * 3 + c] ? win_din[c][r] : '0;
			end
		end
		med_in.frame_end = last_s1;
	end

	mf3_median u_median (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1 && res_s1),
		.in_ready  (med_ready),
		.in_data   (med_in),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

`ifndef SYNTHESIS
	a_col_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		(COL_W + 1)'(col_q) < (COL_W + 1)'(len_q))
		else $error("Column position is outside the line.");

	a_row_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(ROW_W + 1)'(row_q) < (ROW_W + 1)'(rows_q))
		else $error("Row position is outside the frame.");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		shift_cnt_q <= total_q + CNT_W'(len_q))
		else $error("Shift count ran past the end of the frame.");
`endif

endmodule

`default_nettype wire

### rtl/mf3_line_store.sv
// Two-row line store of the median filter: one entry holds the upper and middle pixel.
// One write and one registered read per cycle; depends on mf3_pkg.
`default_nettype none

module mf3_line_store (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [mf3_pkg::COL_W-1:0] wr_addr,
	input  wire mf3_pkg::lpair_t          wr_data,
	input  wire logic                     rd_en,
	input  wire logic [mf3_pkg::COL_W-1:0] rd_addr,
	output mf3_pkg::lpair_t               rd_q
);

	mf3_pkg::lpair_t mem_q [mf3_pkg::MAX_LINE];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### rtl/mf3_column_cell.sv
// One column of the 3x3 window: three pixels that move one cell to the left per shift.
// Depends on mf3_pkg.
`default_nettype none

module mf3_column_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           shift,
	input  wire logic           clear,
	input  wire mf3_pkg::wcol_t din,
	output mf3_pkg::wcol_t      col_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (clear) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= din;
		end
	end

endmodule

`default_nettype wire

### rtl/mf3_median.sv
// Three-stage median-of-nine compare-exchange network with the output register.
// Depends on mf3_pkg.
`default_nettype none

module mf3_median (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire mf3_pkg::med_in_t in_data,
	output logic                  res_valid,
	input  wire logic             res_stall,
	output mf3_pkg::res_word_t    res_word
);

	function automatic mf3_pkg::cells_t cx(mf3_pkg::cells_t p, logic [3:0] i, logic [3:0] j);
		mf3_pkg::cells_t r;
		r = p;
		if (p[i] > p[j]) begin
			r[i] = p[j];
			r[j] = p[i];
		end
		return r;
	endfunction

	logic            valid_s2, valid_s3, valid_s4;
	logic            last_s2, last_s3;
	mf3_pkg::cells_t cells_s2, cells_s3;
	mf3_pkg::cells_t net_a, net_b, net_c;
	logic            adv_s2, adv_s3, adv_s4;

	assign adv_s4 = !valid_s4 || !res_stall;
	assign adv_s3 = !valid_s3 || adv_s4;
	assign adv_s2 = !valid_s2 || adv_s3;
	assign in_ready = adv_s2;
	assign res_valid = valid_s4;

	always_comb begin
		net_a = in_data.cells;
		net_a = cx(net_a, 4'd1, 4'd2);
		net_a = cx(net_a, 4'd4, 4'd5);
		net_a = cx(net_a, 4'd7, 4'd8);
		net_a = cx(net_a, 4'd0, 4'd1);
		net_a = cx(net_a, 4'd3, 4'd4);
		net_a = cx(net_a, 4'd6, 4'd7);
		net_a = cx(net_a, 4'd1, 4'd2);
		net_a = cx(net_a, 4'd4, 4'd5);
		net_a = cx(net_a, 4'd7, 4'd8);
	end

	always_comb begin
		net_b = cells_s2;
		net_b = cx(net_b, 4'd0, 4'd3);
		net_b = cx(net_b, 4'd5, 4'd8);
		net_b = cx(net_b, 4'd4, 4'd7);
		net_b = cx(net_b, 4'd3, 4'd6);
		net_b = cx(net_b, 4'd1, 4'd4);
		net_b = cx(net_b, 4'd2, 4'd5);
		net_b = cx(net_b, 4'd4, 4'd7);
	end

	always_comb begin
		net_c = cells_s3;
		net_c = cx(net_c, 4'd4, 4'd2);
		net_c = cx(net_c, 4'd6, 4'd4);
		net_c = cx(net_c, 4'd4, 4'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv_s2) begin
				valid_s2 <= in_valid;
			end
			if (adv_s3) begin
				valid_s3 <= valid_s2;
			end
			if (adv_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && in_valid) begin
			cells_s2 <= net_a;
			last_s2 <= in_data.frame_end;
		end
		if (adv_s3 && valid_s2) begin
			cells_s3 <= net_b;
			last_s3 <= last_s2;
		end
		if (adv_s4 && valid_s3) begin
			res_word.filtered <= net_c[4];
			res_word.frame_end <= last_s3;
		end
	end

endmodule

`default_nettype wire
